// File: src/polymer_cleavage_gillespie_step_assert.svh
// Assertion macros shared by the polymer cleavage step block.
`ifndef POLYMER_CLEAVAGE_GILLESPIE_STEP_ASSERT_SVH
`define POLYMER_CLEAVAGE_GILLESPIE_STEP_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition that must hold at every clock edge outside reset.
`define PCGS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define PCGS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PCGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PCGS_ASSERT_ALWAYS(label, cond)
`define PCGS_ASSERT_IMP(label, ante, cons)
`define PCGS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: src/pcgs_pkg.sv
// Types, constants and command structs of the polymer cleavage step block.
package pcgs_pkg;

    localparam int CNT_W          = 20;
    localparam int LEN_W          = 11;
    localparam int KEPT_W         = 10;
    localparam int TOT_OUT_W      = 30;
    localparam int FRAC_W         = 32;
    localparam int DEF_MAX_LENGTH = 1024;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic [LEN_W-1:0] PLEN_RESET = 11'd1024;
    localparam logic [CNT_W-1:0] ICNT_RESET = 20'd1000000;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic REG_POLYMER_LENGTH = 1'b0;
    localparam logic REG_INITIAL_COUNT  = 1'b1;

    localparam logic [1:0] ST_STEPPED  = 2'd0;
    localparam logic [1:0] ST_FINISHED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_LOADED   = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [FRAC_W-1:0] pick_fraction;
        logic [FRAC_W-1:0] split_fraction;
    } req_t;

    typedef struct packed {
        logic [LEN_W-1:0]     cut_length;
        logic [KEPT_W-1:0]    kept_length;
        logic [TOT_OUT_W-1:0] total_propensity;
        logic [1:0]           status;
    } rsp_t;

    typedef enum logic [1:0] {
        RES_STEP,
        RES_EMPTY,
        RES_LOADED
    } res_kind_t;

    typedef enum logic [2:0] {
        ADDR_CNT,
        ADDR_LEN,
        ADDR_CUT,
        ADDR_KEPT,
        ADDR_ONE
    } addr_sel_t;

    typedef enum logic [1:0] {
        WR_ZERO,
        WR_INIT,
        WR_DEC,
        WR_INC
    } wr_kind_t;

    typedef struct packed {
        logic      accept;
        logic      cnt_clear;
        logic      scan_init;
        logic      scan_issue;
        logic      cnt_inc;
        logic      rd_en;
        logic      wr_en;
        addr_sel_t addr_sel;
        wr_kind_t  wr_kind;
        logic      search;
        logic      latch_total;
        logic      mul_lo;
        logic      mul_hi;
        logic      form_target;
        logic      mul_kept;
        logic      form_kept;
        logic      latch_fin;
        logic      load_result;
        res_kind_t res_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic pipe_busy;
        logic hit;
        logic total_zero;
    } dp_status_t;

endpackage

// File: src/pcgs_ctrl.sv
// Controller state machine sequencing clear, load, scans and store updates.
module pcgs_ctrl
    import pcgs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_opcode,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_SUM,
        S_SUM_DRAIN,
        S_CHECK,
        S_MUL_LO,
        S_MUL_HI,
        S_TARGET,
        S_SEARCH,
        S_SEARCH_DRAIN,
        S_RD_CUT,
        S_WR_CUT,
        S_RD_KEPT,
        S_WR_KEPT,
        S_RD_ONE,
        S_FIN,
        S_FINISH
    } state_t;

    state_t    state_reg, state_next;
    logic      rsp_valid_reg, rsp_valid_next;
    logic      load_pending_reg, load_pending_next;
    res_kind_t res_kind_reg, res_kind_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        load_pending_next = load_pending_reg;
        res_kind_next     = res_kind_reg;
        rsp_valid_next    = rsp_valid_reg;
        cmd               = '0;
        cmd.addr_sel      = ADDR_CNT;
        cmd.wr_kind       = WR_ZERO;
        cmd.res_kind      = res_kind_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = ADDR_CNT;
                cmd.wr_kind  = WR_ZERO;
                cmd.cnt_inc  = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = load_pending_reg ? S_LOAD : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (req_opcode == OP_START)
                    begin
                        cmd.cnt_clear     = 1'b1;
                        load_pending_next = 1'b1;
                        state_next        = S_CLEAR;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SUM;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.wr_en         = 1'b1;
                cmd.addr_sel      = ADDR_LEN;
                cmd.wr_kind       = WR_INIT;
                load_pending_next = 1'b0;
                res_kind_next     = RES_LOADED;
                state_next        = S_FINISH;
            end
            S_SUM:
            begin
                cmd.scan_issue = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.cnt_inc    = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = S_SUM_DRAIN;
                end
            end
            S_SUM_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    cmd.latch_total = 1'b1;
                    state_next      = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.total_zero)
                begin
                    res_kind_next = RES_EMPTY;
                    state_next    = S_FINISH;
                end
                else
                begin
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_TARGET;
            end
            S_TARGET:
            begin
                cmd.form_target = 1'b1;
                cmd.scan_init   = 1'b1;
                state_next      = S_SEARCH;
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (status.hit)
                begin
                    state_next = S_RD_CUT;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                    cmd.rd_en      = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    if (status.cnt_last)
                    begin
                        state_next = S_SEARCH_DRAIN;
                    end
                end
            end
            S_SEARCH_DRAIN:
            begin
                cmd.search = 1'b1;
                if (status.hit || !status.pipe_busy)
                begin
                    state_next = S_RD_CUT;
                end
            end
            S_RD_CUT:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = ADDR_CUT;
                cmd.mul_kept = 1'b1;
                state_next   = S_WR_CUT;
            end
            S_WR_CUT:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = ADDR_CUT;
                cmd.wr_kind   = WR_DEC;
                cmd.form_kept = 1'b1;
                state_next    = S_RD_KEPT;
            end
            S_RD_KEPT:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = ADDR_KEPT;
                state_next   = S_WR_KEPT;
            end
            S_WR_KEPT:
            begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = ADDR_KEPT;
                cmd.wr_kind  = WR_INC;
                state_next   = S_RD_ONE;
            end
            S_RD_ONE:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = ADDR_ONE;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                cmd.latch_fin = 1'b1;
                res_kind_next = RES_STEP;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                // The result register may still hold an untaken transaction.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_result = 1'b1;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            rsp_valid_reg    <= 1'b0;
            load_pending_reg <= 1'b0;
            res_kind_reg     <= RES_EMPTY;
        end
        else
        begin
            state_reg        <= state_next;
            rsp_valid_reg    <= rsp_valid_next;
            load_pending_reg <= load_pending_next;
            res_kind_reg     <= res_kind_next;
        end
    end

endmodule

// File: src/pcgs_datapath.sv
// Datapath: count memory, scan pipeline, target and split arithmetic, result.
module pcgs_datapath
    import pcgs_pkg::*;
#(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  req_t             req,
    input  logic [LEN_W-1:0] cfg_polymer_length,
    input  logic [CNT_W-1:0] cfg_initial_count,
    output rsp_t             rsp
);

    localparam int DEPTH = MAX_LENGTH + 1;
    localparam int KW    = $clog2(MAX_LENGTH + 1);
    localparam int PW    = CNT_W + KW;
    localparam int TWS   = CNT_W + 2 * KW;
    localparam int TW    = (TWS > 33) ? TWS : 33;
    localparam int HW    = TW - FRAC_W;
    localparam int KPW   = FRAC_W + KW;

    localparam logic [TW-1:0] TOT_SAT = TW'({TOT_OUT_W{1'b1}});

    logic [CNT_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0] rd_data_reg;
    logic [CNT_W-1:0] wr_data;
    logic [KW-1:0]    addr;
    logic [KW-1:0]    eff_len;
    logic [31:0]      len_wide;

    logic [KW-1:0]    cnt_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             hit_reg;
    logic [KW-1:0]    k1_reg;
    logic [KW-1:0]    k2_reg;
    logic [PW-1:0]    prod_reg;
    logic [TW-1:0]    acc_reg;
    logic [TW-1:0]    run_sum;
    logic             hit_now;
    logic [KW-1:0]    cut_reg;

    logic [TW-1:0]          total_reg;
    logic [2*FRAC_W-1:0]    prod_lo_reg;
    logic [TW-1:0]          prod_hi_reg;
    logic [TW-1:0]          target_reg;
    logic [KPW-1:0]         kept_prod_reg;
    logic [KW-1:0]          kept_reg;
    logic                   fin_reg;
    req_t                   req_reg;
    rsp_t                   rsp_reg;
    logic [TOT_OUT_W-1:0]   tot_out;

    // Starting length is clamped into the store.
    always_comb
    begin
        len_wide = 32'(cfg_polymer_length);
        if (len_wide == 32'd0)
        begin
            eff_len = KW'(1);
        end
        else if (len_wide > 32'(MAX_LENGTH))
        begin
            eff_len = KW'(MAX_LENGTH);
        end
        else
        begin
            eff_len = KW'(len_wide);
        end
    end

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_CNT:  addr = cnt_reg;
            ADDR_LEN:  addr = eff_len;
            ADDR_CUT:  addr = cut_reg;
            ADDR_KEPT: addr = kept_reg;
            ADDR_ONE:  addr = KW'(1);
            default:   addr = cnt_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_kind)
            WR_ZERO: wr_data = '0;
            WR_INIT: wr_data = cfg_initial_count;
            WR_DEC:  wr_data = rd_data_reg - CNT_W'(1);
            WR_INC:  wr_data = rd_data_reg + CNT_W'(1);
            default: wr_data = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // Last stage of the scan: running sum, and in search mode the first
    // length whose running sum passes the target.
    assign run_sum = acc_reg + TW'(prod_reg);
    assign hit_now = cmd.search && v2_reg && !hit_reg && (run_sum > target_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan_init)
            begin
                cnt_reg <= KW'(2);
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + KW'(1);
            end

            if (cmd.scan_init)
            begin
                v1_reg  <= 1'b0;
                v2_reg  <= 1'b0;
                hit_reg <= 1'b0;
            end
            else
            begin
                v1_reg <= cmd.scan_issue;
                v2_reg <= v1_reg;
                if (hit_now)
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg   <= cnt_reg;
        k2_reg   <= k1_reg;
        prod_reg <= PW'(rd_data_reg) * PW'(k1_reg - KW'(1));

        if (cmd.accept)
        begin
            req_reg <= req;
        end

        if (cmd.scan_init)
        begin
            acc_reg <= '0;
            cut_reg <= KW'(MAX_LENGTH);
        end
        else
        begin
            if (v2_reg && !hit_reg)
            begin
                acc_reg <= run_sum;
            end
            if (hit_now)
            begin
                cut_reg <= k2_reg;
            end
        end

        if (cmd.latch_total)
        begin
            total_reg <= acc_reg;
        end
        if (cmd.mul_lo)
        begin
            prod_lo_reg <= (2*FRAC_W)'(req_reg.pick_fraction)
                         * (2*FRAC_W)'(total_reg[FRAC_W-1:0]);
        end
        if (cmd.mul_hi)
        begin
            prod_hi_reg <= TW'(req_reg.pick_fraction) * TW'(total_reg[TW-1:FRAC_W]);
        end
        if (cmd.form_target)
        begin
            target_reg <= prod_hi_reg + TW'(prod_lo_reg[2*FRAC_W-1:FRAC_W]);
        end

        if (cmd.mul_kept)
        begin
            kept_prod_reg <= KPW'(req_reg.split_fraction) * KPW'(cut_reg - KW'(1));
        end
        if (cmd.form_kept)
        begin
            kept_reg <= kept_prod_reg[KPW-1:FRAC_W] + KW'(1);
        end

        if (cmd.latch_fin)
        begin
            fin_reg <= (rd_data_reg == cfg_initial_count);
        end

        if (cmd.load_result)
        begin
            case (cmd.res_kind)
                RES_STEP:
                begin
                    rsp_reg.cut_length       <= LEN_W'(cut_reg);
                    rsp_reg.kept_length      <= KEPT_W'(kept_reg);
                    rsp_reg.total_propensity <= tot_out;
                    rsp_reg.status           <= fin_reg ? ST_FINISHED : ST_STEPPED;
                end
                RES_LOADED:
                begin
                    rsp_reg <= {LEN_W'(0), KEPT_W'(0), TOT_OUT_W'(0), ST_LOADED};
                end
                default:
                begin
                    rsp_reg <= {LEN_W'(0), KEPT_W'(0), TOT_OUT_W'(0), ST_EMPTY};
                end
            endcase
        end
    end

    assign tot_out = (total_reg > TOT_SAT) ? {TOT_OUT_W{1'b1}} : total_reg[TOT_OUT_W-1:0];

    assign status.cnt_last   = (cnt_reg == KW'(MAX_LENGTH));
    assign status.pipe_busy  = v1_reg | v2_reg;
    assign status.hit        = hit_reg;
    assign status.total_zero = (total_reg == '0);

    assign rsp = rsp_reg;

endmodule

// File: src/polymer_cleavage_gillespie_step.sv
// Polymer cleavage step block: one stochastic fragmentation reaction per step.
// Requests arrive on req (valid/ready); results leave on rsp (valid/ready),
// one result transaction per request transaction. polymer_length and
// initial_count sit on an APB port at byte addresses 0 and 4.
// A start request clears the count memory, one entry per cycle, and loads
// initial_count at the starting length.
// A step request scans the count memory once to total the propensity
// (MAX_LENGTH - 1 reads through a three-stage read/multiply/add pipeline),
// forms the target, scans again until the running sum passes the target,
// then updates two counts and reads count[1].
// One request is worked on at a time; req_ready is high only while idle.
// The result register lets a new request be taken while an earlier result
// waits; if the receiver stalls, the next result waits in the final state.
// After reset the memory is cleared while req_ready stays low;
// configuration writes are taken at any time.
`include "polymer_cleavage_gillespie_step_assert.svh"

module polymer_cleavage_gillespie_step
    import pcgs_pkg::*;
#(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [LEN_W-1:0] polymer_length_reg;
    logic [CNT_W-1:0] initial_count_reg;
    logic             cfg_write;
    dp_cmd_t          cmd;
    dp_status_t       status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polymer_length_reg <= PLEN_RESET;
            initial_count_reg  <= ICNT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_POLYMER_LENGTH: polymer_length_reg <= pwdata[LEN_W-1:0];
                REG_INITIAL_COUNT:  initial_count_reg  <= pwdata[CNT_W-1:0];
                default:            polymer_length_reg <= polymer_length_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_POLYMER_LENGTH: prdata = APB_DW'(polymer_length_reg);
            REG_INITIAL_COUNT:  prdata = APB_DW'(initial_count_reg);
            default:            prdata = '0;
        endcase
    end

    pcgs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_opcode (req.opcode),
        .req_ready  (req_ready),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .cmd        (cmd),
        .status     (status)
    );

    pcgs_datapath #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .req                (req),
        .cfg_polymer_length (polymer_length_reg),
        .cfg_initial_count  (initial_count_reg),
        .rsp                (rsp)
    );

    // A request transaction always makes the block busy in the cycle after it.
    `PCGS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

    // A new result only appears after the block has been working.
    `PCGS_ASSERT_IMP(a_rsp_after_work, $rose(rsp_valid), !$past(req_ready))

    // A load result carries no lengths and no propensity.
    `PCGS_ASSERT_IMP(a_loaded_clean, rsp_valid && rsp.status == ST_LOADED, rsp.cut_length == '0 && rsp.kept_length == '0 && rsp.total_propensity == '0)

    // The memory port never reads and writes in the same cycle.
    `PCGS_ASSERT_ALWAYS(a_one_port_op, !(cmd.rd_en && cmd.wr_en))

endmodule

// File: test/polymer_cleavage_gillespie_step_tb.sv
// Self-checking testbench for the polymer cleavage Gillespie step block.
`timescale 1ns / 100ps

module polymer_cleavage_gillespie_step_tb;
    import pcgs_pkg::*;

    localparam int MAXLEN = DEF_MAX_LENGTH;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 2 * MAXLEN + 64;
    localparam logic [63:0] TOTAL_CEIL = (64'd1 << TOT_OUT_W) - 64'd1;

    // Tracks the molecule count per length and the results the block owes.
    class reaction_scoreboard;
        logic [CNT_W-1:0] stock [0:MAXLEN];
        logic [LEN_W-1:0] length_setting;
        logic [CNT_W-1:0] load_count;
        rsp_t awaited_results [$];
        int failures;

        function new();
            length_setting = PLEN_RESET;
            load_count = ICNT_RESET;
            for (int k = 0; k <= MAXLEN; k++)
                stock[k] = '0;
            failures = 0;
        endfunction

        function void set_register(logic index, logic [APB_DW-1:0] value);
            if (index == REG_POLYMER_LENGTH)
                length_setting = value[LEN_W-1:0];
            else
                load_count = value[CNT_W-1:0];
        endfunction

        // Applies one accepted request to the counts and queues its result.
        function void note_request(req_t item);
            rsp_t outcome;
            bit [63:0] total;
            bit [63:0] target;
            bit [63:0] running;
            bit [95:0] prod;
            int k;
            int eff_len;
            int cut;
            int kept;
            outcome = '0;
            if (item.opcode == OP_START) begin
                eff_len = length_setting;
                if (eff_len < 1)
                    eff_len = 1;
                if (eff_len > MAXLEN)
                    eff_len = MAXLEN;
                for (k = 0; k <= MAXLEN; k++)
                    stock[k] = '0;
                stock[eff_len] = load_count;
                outcome.status = ST_LOADED;
            end
            else begin
                total = '0;
                for (k = 2; k <= MAXLEN; k++)
                    total += 64'(stock[k]) * 64'(k - 1);
                if (total == 0) begin
                    outcome.status = ST_EMPTY;
                end
                else begin
                    prod = item.pick_fraction * total;
                    target = prod[95:32];
                    running = '0;
                    cut = 0;
                    for (k = 2; k <= MAXLEN && cut == 0; k++) begin
                        running += 64'(stock[k]) * 64'(k - 1);
                        if (running > target)
                            cut = k;
                    end
                    if (cut == 0)
                        cut = MAXLEN;
                    prod = item.split_fraction * 96'(cut - 1);
                    kept = 1 + int'(prod[63:32]);
                    stock[cut] = stock[cut] - 1'b1;
                    stock[kept] = stock[kept] + 1'b1;
                    outcome.cut_length = cut[LEN_W-1:0];
                    outcome.kept_length = kept[KEPT_W-1:0];
                    outcome.total_propensity = (total > TOTAL_CEIL) ?
                        TOTAL_CEIL[TOT_OUT_W-1:0] : total[TOT_OUT_W-1:0];
                    outcome.status = (stock[1] == load_count) ? ST_FINISHED : ST_STEPPED;
                end
            end
            awaited_results = {awaited_results, outcome};
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (awaited_results.size() == 0) begin
                $error("result transaction with nothing awaited, status %0d", got.status);
                failures++;
            end
            else begin
                want = awaited_results.pop_front();
                compare_field("cut_length", want.cut_length, got.cut_length);
                compare_field("kept_length", want.kept_length, got.kept_length);
                compare_field("total_propensity", want.total_propensity,
                              got.total_propensity);
                compare_field("status", want.status, got.status);
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_t              req = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_t              rsp;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int cycle_count = 0;
    reaction_scoreboard sb = new();

    polymer_cleavage_gillespie_step uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("polymer_cleavage_gillespie_step regression: fail");
        $finish;
    end

    // Result side: checks each completed transaction and stalls at random.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp);
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [FRAC_W-1:0] rand_fraction();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        else if (roll < 16)
            return '1;
        return $urandom();
    endfunction

    function automatic req_t build_request(logic op, logic [FRAC_W-1:0] pick,
                                           logic [FRAC_W-1:0] split);
        req_t item;
        item.opcode = op;
        item.pick_fraction = pick;
        item.split_fraction = split;
        return item;
    endfunction

    // Presents one request and returns at the edge where it is accepted.
    task automatic send_item(input req_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(item);
    endtask

    task automatic send_random(input logic op);
        send_item(build_request(op, rand_fraction(), rand_fraction()));
    endtask

    // Lets every owed result come back so the block is idle.
    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(index, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input int len, input int count);
        drain();
        write_register(REG_POLYMER_LENGTH, len);
        write_register(REG_INITIAL_COUNT, count);
    endtask

    task automatic run_random_phase(input int quota);
        int sent;
        int steps;
        int len;
        int count;
        int unsigned roll;
        sent = 0;
        while (sent < quota)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
            begin
                // Short polymers and few molecules reach the finished state quickly.
                len = $urandom_range(2, 12);
                count = $urandom_range(1, 8);
            end
            else if (roll < 80)
            begin
                len = $urandom_range(2, MAXLEN);
                count = $urandom_range(1, (1 << CNT_W) - 1);
            end
            else if (roll < 90)
            begin
                case ($urandom_range(5))
                    0: len = 0;
                    1: len = 1;
                    2: len = 2;
                    3: len = MAXLEN;
                    4: len = MAXLEN + 1;
                    default: len = (1 << LEN_W) - 1;
                endcase
                case ($urandom_range(2))
                    0: count = 0;
                    1: count = 1;
                    default: count = (1 << CNT_W) - 1;
                endcase
            end
            else
            begin
                len = $urandom_range(0, (1 << LEN_W) - 1);
                count = $urandom_range(0, (1 << CNT_W) - 1);
            end
            configure(len, count);
            // Most runs reload; the rest keep the old store, stray lengths included.
            if ($urandom_range(99) < 85)
            begin
                send_random(OP_START);
                sent++;
            end
            steps = $urandom_range(4, 16);
            repeat (steps)
            begin
                send_random(($urandom_range(99) < 6) ? OP_START : OP_STEP);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 22;
        recv_idle_pct = 68;

        // Reset configuration: a step on the cleared store has nothing to cut.
        send_item(build_request(OP_STEP, '0, '0));
        send_item(build_request(OP_START, '0, '0));
        send_item(build_request(OP_STEP, '0, '0));
        send_item(build_request(OP_STEP, '1, '1));
        send_item(build_request(OP_STEP, 32'h8000_0000, 32'h8000_0000));

        // Three dimers: the third cut finishes the run, the next finds nothing.
        configure(2, 3);
        send_item(build_request(OP_START, '0, '0));
        send_random(OP_STEP);
        send_item(build_request(OP_STEP, '0, '1));
        send_item(build_request(OP_STEP, '1, '0));
        send_random(OP_STEP);

        // A length of zero is raised to one, which leaves nothing to cut.
        configure(0, 5);
        send_item(build_request(OP_START, '0, '0));
        send_random(OP_STEP);

        // Oversized length is clamped; the largest count gives the widest total.
        configure((1 << LEN_W) - 1, (1 << CNT_W) - 1);
        send_item(build_request(OP_START, '0, '0));
        send_item(build_request(OP_STEP, '0, '0));
        send_item(build_request(OP_STEP, '1, '1));

        configure(1, 0);
        send_item(build_request(OP_START, '0, '0));
        send_random(OP_STEP);

        // Lowering the length without a reload keeps the long molecules in play.
        configure(MAXLEN, 2);
        send_item(build_request(OP_START, '0, '0));
        send_random(OP_STEP);
        configure(3, 2);
        send_random(OP_STEP);
        send_random(OP_STEP);

        configure(MAXLEN + 1, 4);
        send_item(build_request(OP_START, '0, '0));
        send_item(build_request(OP_STEP, '1, '0));

        run_random_phase(85);
        drain();
        send_idle_pct = 68;
        recv_idle_pct = 22;
        run_random_phase(85);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(85);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("polymer_cleavage_gillespie_step regression: pass");
        else
            $display("polymer_cleavage_gillespie_step regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/pcgs_pkg.sv
src/pcgs_ctrl.sv
src/pcgs_datapath.sv
src/polymer_cleavage_gillespie_step.sv
test/polymer_cleavage_gillespie_step_tb.sv
